@@ rtl/asfr_pkg.sv @@
// Shared types and constants for the addressed serial frame receiver.
// No dependencies; every other file imports this package.
package asfr_pkg;

    localparam int DATA_W  = 8;
    localparam int LEN_W   = 3;
    localparam int TICK_W  = 17;
    localparam int CFG_W   = 17;
    localparam int CFG_IDX_W = 3;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    localparam logic [DATA_W-1:0] RST_CMD_RESET    = 8'd17;
    localparam logic [DATA_W-1:0] RST_CMD_FIRMWARE = 8'd112;
    localparam logic [DATA_W-1:0] RST_CMD_DISPLAY  = 8'd32;
    localparam logic [LEN_W-1:0]  RST_LEN_SHORT    = 3'd1;
    localparam logic [LEN_W-1:0]  RST_LEN_DISPLAY  = 3'd4;
    localparam logic [DATA_W-1:0] RST_PANEL_ADDR   = 8'd1;
    localparam logic [TICK_W-1:0] RST_TIMEOUT      = 17'h10000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CMD_RESET    = 3'd0,
        REG_CMD_FIRMWARE = 3'd1,
        REG_CMD_DISPLAY  = 3'd2,
        REG_LEN_SHORT    = 3'd3,
        REG_LEN_DISPLAY  = 3'd4,
        REG_PANEL_ADDR   = 3'd5,
        REG_TIMEOUT      = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SHOW
    } t_state;

    typedef struct packed {
        logic take;
        logic rd_en;
        logic advance;
    } t_cmd;

    typedef struct packed {
        logic emit_start;
        logic out_last;
        logic count_zero;
    } t_status;

endpackage

@@ rtl/asfr_ctrl.sv @@
// Controller state machine for the frame receiver: request handshakes and
// frame readout sequencing. Depends on asfr_pkg.
module asfr_ctrl
    import asfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    output logic    o_m_tvalid,
    input  logic    i_m_tready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_s_tready  = 1'b0;
        o_m_tvalid  = 1'b0;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.take = i_s_tvalid;
                if (i_s_tvalid && i_status.emit_start) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = ST_SHOW;
            end
            ST_SHOW: begin
                o_m_tvalid = 1'b1;
                // accept a request that cannot finish a frame under the last byte
                o_s_tready = i_status.out_last && i_status.count_zero;
                o_cmd.take = o_s_tready && i_s_tvalid;
                if (i_m_tready) begin
                    if (i_status.out_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.advance = 1'b1;
                        n_state       = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/asfr_dp.sv @@
// Datapath for the frame receiver: configuration registers, parity and
// header checks, frame store memory and readout registers. Depends on asfr_pkg.
module asfr_dp
    import asfr_pkg::*;
#(
    parameter int BUFFER_DEPTH = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic [DATA_W-1:0]     i_rx_byte,
    input  logic                  i_ninth_bit,
    input  logic                  i_operation,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    output logic [DATA_W-1:0]     o_frame_byte,
    output logic [LEN_W-1:0]      o_frame_index,
    output logic                  o_frame_last
);

    localparam int PW = $clog2(BUFFER_DEPTH);
    localparam logic [PW-1:0] MAX_IDX = PW'(BUFFER_DEPTH - 1);

    logic [DATA_W-1:0] r_cmd_reset;
    logic [DATA_W-1:0] r_cmd_firmware;
    logic [DATA_W-1:0] r_cmd_display;
    logic [LEN_W-1:0]  r_len_short;
    logic [LEN_W-1:0]  r_len_display;
    logic [DATA_W-1:0] r_panel_addr;
    logic [TICK_W-1:0] r_timeout;

    logic [PW-1:0]     r_count;
    logic [PW-1:0]     n_count;
    logic [PW-1:0]     r_expected;
    logic [PW-1:0]     n_expected;
    logic [TICK_W-1:0] r_idle;
    logic [TICK_W-1:0] n_idle;
    logic [PW-1:0]     r_rd_ptr;
    logic [PW-1:0]     r_emit_last;
    logic [DATA_W-1:0] r_rd_data;
    logic [LEN_W-1:0]  r_out_idx;
    logic              r_out_last;

    logic [DATA_W-1:0] mem [BUFFER_DEPTH];

    logic              w_parity_ok;
    logic [LEN_W-1:0]  w_len;
    logic [PW-1:0]     w_len_clamped;
    logic [TICK_W-1:0] w_idle_inc;
    logic              w_timeout_hit;
    logic              w_addr_ok;
    logic              w_complete;
    logic              w_wr_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_reset    <= RST_CMD_RESET;
            r_cmd_firmware <= RST_CMD_FIRMWARE;
            r_cmd_display  <= RST_CMD_DISPLAY;
            r_len_short    <= RST_LEN_SHORT;
            r_len_display  <= RST_LEN_DISPLAY;
            r_panel_addr   <= RST_PANEL_ADDR;
            r_timeout      <= RST_TIMEOUT;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_CMD_RESET:    r_cmd_reset    <= i_cfg_data[DATA_W-1:0];
                REG_CMD_FIRMWARE: r_cmd_firmware <= i_cfg_data[DATA_W-1:0];
                REG_CMD_DISPLAY:  r_cmd_display  <= i_cfg_data[DATA_W-1:0];
                REG_LEN_SHORT:    r_len_short    <= i_cfg_data[LEN_W-1:0];
                REG_LEN_DISPLAY:  r_len_display  <= i_cfg_data[LEN_W-1:0];
                REG_PANEL_ADDR:   r_panel_addr   <= i_cfg_data[DATA_W-1:0];
                REG_TIMEOUT:      r_timeout      <= i_cfg_data[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_parity_ok = ^{i_ninth_bit, i_rx_byte};
        if (i_rx_byte == r_cmd_reset || i_rx_byte == r_cmd_firmware) begin
            w_len = r_len_short;
        end else if (i_rx_byte == r_cmd_display) begin
            w_len = r_len_display;
        end else begin
            w_len = '0;
        end
        w_len_clamped = (32'(w_len) > BUFFER_DEPTH - 1) ? MAX_IDX : PW'(w_len);
        w_idle_inc    = r_idle + TICK_W'(1);
        w_timeout_hit = (w_idle_inc >= r_timeout) || (w_idle_inc == '0);
        w_addr_ok     = (r_count != PW'(1)) || (i_rx_byte == r_panel_addr);
        w_complete    = !i_operation && w_parity_ok && (r_count != '0) && w_addr_ok
                        && (r_count == r_expected);
    end

    always_comb begin
        n_count    = r_count;
        n_expected = r_expected;
        n_idle     = r_idle;
        w_wr_en    = 1'b0;
        if (i_cmd.take) begin
            if (i_operation) begin
                if (r_count != '0) begin
                    if (w_timeout_hit) begin
                        n_count    = '0;
                        n_expected = '0;
                        n_idle     = '0;
                    end else begin
                        n_idle = w_idle_inc;
                    end
                end
            end else begin
                n_idle = '0;
                if (!w_parity_ok) begin
                    n_count    = '0;
                    n_expected = '0;
                end else if (r_count == '0) begin
                    n_expected = w_len_clamped;
                    if (w_len_clamped != '0) begin
                        w_wr_en = 1'b1;
                        n_count = PW'(1);
                    end
                end else if (!w_addr_ok) begin
                    n_count    = '0;
                    n_expected = '0;
                end else begin
                    w_wr_en = 1'b1;
                    if (r_count == r_expected) begin
                        n_count    = '0;
                        n_expected = '0;
                    end else begin
                        n_count = r_count + PW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_expected  <= '0;
            r_idle      <= '0;
            r_rd_ptr    <= '0;
            r_emit_last <= '0;
        end else begin
            r_count    <= n_count;
            r_expected <= n_expected;
            r_idle     <= n_idle;
            if (i_cmd.take && w_complete) begin
                r_rd_ptr    <= '0;
                r_emit_last <= r_expected;
            end else if (i_cmd.advance) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[r_count] <= i_rx_byte;
        end
        if (i_cmd.rd_en) begin
            r_rd_data  <= mem[r_rd_ptr];
            r_out_idx  <= LEN_W'(r_rd_ptr);
            r_out_last <= (r_rd_ptr == r_emit_last);
        end
    end

    assign o_status.emit_start = w_complete;
    assign o_status.out_last   = r_out_last;
    assign o_status.count_zero = (r_count == '0);
    assign o_frame_byte        = r_rd_data;
    assign o_frame_index       = r_out_idx;
    assign o_frame_last        = r_out_last;

endmodule

@@ rtl/addressed_serial_frame_receiver.sv @@
// Top level of the addressed serial frame receiver: joins controller and
// datapath and maps the stream and configuration ports. Depends on asfr_pkg,
// asfr_ctrl and asfr_dp.
//
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  tdata: rx_byte, ninth_bit; tuser: operation
//  m_axis    out        m_axis_tvalid/m_axis_tready  tdata: frame_byte, frame_index; tlast
//  cfg       in         i_cfg_we                     i_cfg_index, i_cfg_data
//
// A byte or tick that does not finish a frame is taken while idle and keeps the
// controller idle. A finishing byte starts readout from the frame store memory:
// each frame byte is first read from memory, then shown until the output takes
// it. Input waits during readout, except under the last byte when no frame is
// open. Reset is synchronous; the store needs no clearing.
module addressed_serial_frame_receiver
    import asfr_pkg::*;
#(
    parameter int BUFFER_DEPTH = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] rx_byte, [8] ninth_bit
    input  logic                   s_axis_tuser,   // [0] operation
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [7:0] frame_byte, [10:8] frame_index
    output logic                   m_axis_tlast
);

    t_cmd              w_cmd;
    t_status           w_status;
    logic [DATA_W-1:0] w_frame_byte;
    logic [LEN_W-1:0]  w_frame_index;

    asfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    asfr_dp #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_rx_byte     (s_axis_tdata[7:0]),
        .i_ninth_bit   (s_axis_tdata[8]),
        .i_operation   (s_axis_tuser),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_frame_byte  (w_frame_byte),
        .o_frame_index (w_frame_index),
        .o_frame_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - DATA_W - LEN_W){1'b0}}, w_frame_index, w_frame_byte};

    a_take_only_under_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tready && m_axis_tvalid) |-> (m_axis_tlast && w_status.count_zero))
        else $error("request taken while a frame byte other than the last is shown");

    a_read_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> (!m_axis_tvalid ##1 m_axis_tvalid))
        else $error("frame readout did not continue after a non-last byte");

    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> ##1
        (m_axis_tdata[10:8] == 3'($past(m_axis_tdata[10:8], 2) + 3'd1)))
        else $error("frame index did not advance by one");

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for addressed_serial_frame_receiver: drives bytes and ticks,
// predicts emitted frames in a local model and compares each output beat in order.
// Depends on asfr_pkg and the addressed_serial_frame_receiver RTL.
module tb_top;
    import asfr_pkg::*;

    localparam int FRAME_DEPTH   = 8;
    localparam int SETTLE_CYCLES = 2 * FRAME_DEPTH + 8;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    typedef struct packed {
        logic [DATA_W-1:0] cmd_reset;
        logic [DATA_W-1:0] cmd_firmware;
        logic [DATA_W-1:0] cmd_display;
        logic [LEN_W-1:0]  len_short;
        logic [LEN_W-1:0]  len_display;
        logic [DATA_W-1:0] panel_addr;
        logic [TICK_W-1:0] timeout;
    } t_settings;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [LEN_W-1:0]  index;
        logic              last;
    } t_frame_beat;

    logic                   i_clk;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_W-1:0]       i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [7:0] rx_byte, [8] ninth_bit
    logic                   s_axis_tuser = 1'b0; // [0] operation
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [7:0] frame_byte, [10:8] frame_index
    logic                   m_axis_tlast;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int rx_bytes_sent  = 0;
    int mismatch_count = 0;

    t_settings   cfg_now;
    logic [DATA_W-1:0] rx_store [FRAME_DEPTH];
    logic [3:0]        rx_count;
    logic [LEN_W-1:0]  rx_last_idx;
    logic              rx_open;
    logic [TICK_W-1:0] idle_ticks;
    t_frame_beat       frame_beats_due [$];

    addressed_serial_frame_receiver #(
        .BUFFER_DEPTH(FRAME_DEPTH)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic void abandon_frame();
        rx_count    = '0;
        rx_last_idx = '0;
        rx_open     = 1'b0;
        idle_ticks  = '0;
    endfunction

    function automatic void predict_frame(input t_op op, input logic [7:0] b, input logic ninth);
        logic [LEN_W-1:0] len;
        int total;
        if (op == OP_TICK) begin
            if (rx_open) begin
                idle_ticks = idle_ticks + 1'b1;
                if (idle_ticks >= cfg_now.timeout || idle_ticks == '0)
                    abandon_frame();
            end
            return;
        end
        idle_ticks = '0;
        if ((^{ninth, b}) == 1'b0) begin
            abandon_frame();
            return;
        end
        if (rx_count == 0) begin
            len = '0;
            if (b == cfg_now.cmd_reset || b == cfg_now.cmd_firmware)
                len = cfg_now.len_short;
            else if (b == cfg_now.cmd_display)
                len = cfg_now.len_display;
            if (len > FRAME_DEPTH - 1)
                len = LEN_W'(FRAME_DEPTH - 1);
            rx_last_idx = len;
            if (len != 0) begin
                rx_store[0] = b;
                rx_count    = 1;
                rx_open     = 1'b1;
            end
            return;
        end else if (rx_count == 1) begin
            if (b != cfg_now.panel_addr) begin
                abandon_frame();
                return;
            end
            rx_store[1] = b;
            rx_count    = 2;
        end else if (rx_count <= rx_last_idx && rx_count < FRAME_DEPTH) begin
            rx_store[rx_count] = b;
            rx_count = rx_count + 1'b1;
        end
        if (rx_count > rx_last_idx) begin
            total = (rx_count > FRAME_DEPTH) ? FRAME_DEPTH : rx_count;
            for (int k = 0; k < total; k++)
                frame_beats_due.push_back('{data: rx_store[k], index: LEN_W'(k),
                                            last: (k == total - 1)});
            foreach (rx_store[k])
                rx_store[k] = '0;
            abandon_frame();
        end
    endfunction

    function automatic void flag_mismatch(input string what, input t_frame_beat want,
                                          input t_frame_beat got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t %s: expected byte %02h index %0d last %0d,",
                     $time, what, want.data, want.index, want.last,
                     " got byte %02h index %0d last %0d",
                     got.data, got.index, got.last);
    endfunction

    always @(posedge i_clk) begin : check_beats
        t_frame_beat got;
        t_frame_beat want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{data: m_axis_tdata[7:0], index: m_axis_tdata[10:8], last: m_axis_tlast};
            if (frame_beats_due.size() == 0) begin
                flag_mismatch("unexpected frame byte", '0, got);
            end else begin
                want = frame_beats_due.pop_front();
                if (got.data != want.data || got.index != want.index || got.last != want.last)
                    flag_mismatch("frame byte mismatch", want, got);
            end
        end
    end

    task automatic send_request(input t_op op, input logic [7:0] b, input logic ninth);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(IN_TDATA_W - 9){1'b0}}, ninth, b};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        predict_frame(op, b, ninth);
        if (op == OP_BYTE)
            rx_bytes_sent++;
    endtask

    task automatic send_good(input logic [7:0] b);
        send_request(OP_BYTE, b, ~^b);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (frame_beats_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_settings(input t_settings s);
        t_reg_idx idx;
        idx = idx.first();
        repeat (idx.num()) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx;
            case (idx)
                REG_CMD_RESET:    i_cfg_data <= CFG_W'(s.cmd_reset);
                REG_CMD_FIRMWARE: i_cfg_data <= CFG_W'(s.cmd_firmware);
                REG_CMD_DISPLAY:  i_cfg_data <= CFG_W'(s.cmd_display);
                REG_LEN_SHORT:    i_cfg_data <= CFG_W'(s.len_short);
                REG_LEN_DISPLAY:  i_cfg_data <= CFG_W'(s.len_display);
                REG_PANEL_ADDR:   i_cfg_data <= CFG_W'(s.panel_addr);
                default:          i_cfg_data <= CFG_W'(s.timeout);
            endcase
            @(posedge i_clk);
            idx = idx.next();
        end
        i_cfg_we <= 1'b0;
        cfg_now = s;
    endtask

    task automatic send_random_byte(input logic [7:0] b);
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3)) send_request(OP_TICK, 8'($urandom), 1'($urandom));
        if ($urandom_range(0, 29) == 0)
            send_request(OP_BYTE, b, ^b);
        else
            send_request(OP_BYTE, b, ~^b);
    endtask

    task automatic send_random_frame();
        logic [7:0] cmd;
        logic [LEN_W-1:0] len;
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 6)
            cmd = cfg_now.cmd_reset;
        else if (pick < 12)
            cmd = cfg_now.cmd_firmware;
        else if (pick < 18)
            cmd = cfg_now.cmd_display;
        else
            cmd = 8'($urandom);
        if (cmd == cfg_now.cmd_reset || cmd == cfg_now.cmd_firmware)
            len = cfg_now.len_short;
        else if (cmd == cfg_now.cmd_display)
            len = cfg_now.len_display;
        else
            len = '0;
        send_random_byte(cmd);
        send_random_byte(($urandom_range(0, 9) == 0) ? 8'($urandom) : cfg_now.panel_addr);
        for (int k = 2; k <= len; k++)
            send_random_byte(8'($urandom));
    endtask

    task automatic test_default_frames();
        send_request(OP_TICK, 8'hA5, 1'b1);
        send_good(RST_CMD_RESET);
        send_good(RST_PANEL_ADDR);
        send_good(RST_CMD_DISPLAY);
        send_good(RST_PANEL_ADDR);
        send_good(8'h00);
        send_good(8'hFF);
        send_good(8'h5A);
    endtask

    task automatic test_rejected_bytes();
        send_good(8'h99);
        send_good(RST_CMD_FIRMWARE);
        send_good(8'h02);
        send_request(OP_BYTE, RST_CMD_RESET, ^RST_CMD_RESET);
        send_good(RST_CMD_DISPLAY);
        send_good(RST_PANEL_ADDR);
        send_request(OP_BYTE, 8'h3C, ^8'h3C);
        send_good(RST_CMD_FIRMWARE);
        send_good(RST_PANEL_ADDR);
    endtask

    task automatic test_shared_codes_and_latching();
        t_settings s;
        s = '{cmd_reset: 8'h00, cmd_firmware: 8'h00, cmd_display: 8'h00, len_short: 3'd0,
              len_display: 3'd2, panel_addr: 8'hFF, timeout: 17'd0};
        wait_idle();
        load_settings(s);
        send_good(8'h00);
        send_good(8'hFF);
        wait_idle();
        s.len_short = 3'd3;
        load_settings(s);
        send_good(8'h00);
        send_request(OP_TICK, 8'h00, 1'b0);
        send_good(8'h00);
        send_good(8'hFF);
        // change the length once idle; bytes that match no command code open no frame
        wait_idle();
        s.len_short = 3'd1;
        load_settings(s);
        send_good(8'h12);
        send_good(8'h34);
    endtask

    task automatic test_random_frames(input t_settings s, input int idle_pct,
                                      input int stall_pct, input int n_bytes);
        int target;
        wait_idle();
        load_settings(s);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target = rx_bytes_sent + n_bytes;
        while (rx_bytes_sent < target) begin
            if ($urandom_range(0, 9) == 0)
                send_request(OP_BYTE, 8'($urandom), 1'($urandom));
            else
                send_random_frame();
        end
    endtask

    initial begin
        t_settings defaults;
        defaults = '{cmd_reset: RST_CMD_RESET, cmd_firmware: RST_CMD_FIRMWARE,
                     cmd_display: RST_CMD_DISPLAY, len_short: RST_LEN_SHORT,
                     len_display: RST_LEN_DISPLAY, panel_addr: RST_PANEL_ADDR,
                     timeout: RST_TIMEOUT};
        cfg_now = defaults;
        foreach (rx_store[k])
            rx_store[k] = '0;
        abandon_frame();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_default_frames();
        test_rejected_bytes();
        test_shared_codes_and_latching();

        test_random_frames(defaults, 0, 0, 50);
        test_random_frames('{8'($urandom), 8'($urandom), 8'($urandom), 3'd7, 3'd7,
                             8'($urandom), 17'd1}, 48, 0, 50);
        test_random_frames('{8'h00, 8'hFF, 8'($urandom), 3'($urandom_range(1, 7)),
                             3'($urandom), 8'h00, 17'h10000}, 0, 48, 50);
        test_random_frames('{8'($urandom), 8'($urandom), 8'($urandom), 3'($urandom),
                             3'($urandom), 8'($urandom), 17'($urandom_range(0, 5))},
                           22, 22, 50);

        wait_idle();
        if (mismatch_count == 0 && frame_beats_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/asfr_pkg.sv
rtl/asfr_ctrl.sv
rtl/asfr_dp.sv
rtl/addressed_serial_frame_receiver.sv
tb/sv/tb_top.sv
